@@ src/cle_pkg.sv @@
// Shared constants, codes and interface structs of the convolution layer engine.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package cle_pkg;

  // Store capacities
  localparam int MAX_IN_CH  = 16;
  localparam int MAX_OUT_CH = 16;
  localparam int MAX_KERNEL = 8;
  localparam int MAX_DIM    = 64;

  localparam int IC_W  = $clog2(MAX_IN_CH);
  localparam int OC_W  = $clog2(MAX_OUT_CH);
  localparam int KER_W = $clog2(MAX_KERNEL);
  localparam int DIM_W = $clog2(MAX_DIM);

  localparam int W_ADDR_W = OC_W + IC_W + 2 * KER_W;
  localparam int I_ADDR_W = IC_W + 2 * DIM_W;
  localparam int W_DEPTH  = 2 ** W_ADDR_W;
  localparam int I_DEPTH  = 2 ** I_ADDR_W;

  // Upper limits of the effective register values
  localparam int NIC_MAX = (MAX_IN_CH < 16) ? MAX_IN_CH : 16;
  localparam int NOC_MAX = (MAX_OUT_CH < 16) ? MAX_OUT_CH : 16;
  localparam int K_MAX   = (MAX_KERNEL < 8) ? MAX_KERNEL : 8;
  localparam int DIM_MAX = (MAX_DIM < 64) ? MAX_DIM : 64;

  // Fixed field widths
  localparam int FUNC_W     = 2;
  localparam int CH_W       = 4;
  localparam int POS_W      = 6;
  localparam int VAL_W      = 16;
  localparam int PROD_W     = 2 * VAL_W;
  localparam int RES_W      = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;

  // Item kinds
  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD_W  = 2'd0,
    FUNC_LOAD_B  = 2'd1,
    FUNC_LOAD_P  = 2'd2,
    FUNC_COMPUTE = 2'd3
  } func_e;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IN_CH  = 3'd0,
    REG_OUT_CH = 3'd1,
    REG_KSIZE  = 3'd2,
    REG_STRIDE = 3'd3,
    REG_PAD    = 3'd4,
    REG_WIDTH  = 3'd5,
    REG_HEIGHT = 3'd6
  } cfg_reg_e;

  // Effective (saturated) layer geometry
  typedef struct packed {
    logic [4:0] nic;
    logic [4:0] noc;
    logic [3:0] ksize;
    logic [2:0] stride;
    logic [2:0] pad;
    logic [6:0] width;
    logic [6:0] height;
    logic [6:0] out_w;
    logic [6:0] out_h;
  } cfg_t;

  // Store access for one cycle
  typedef struct packed {
    logic                w_we;
    logic [W_ADDR_W-1:0] w_addr;
    logic                i_we;
    logic [I_ADDR_W-1:0] i_addr;
    logic                b_we;
    logic [OC_W-1:0]     b_addr;
    logic [VAL_W-1:0]    wdata;
  } store_req_t;

  // Accumulator control
  typedef struct packed {
    logic init;
    logic tap_vld;
  } mac_ctl_t;

endpackage

@@ src/cle_cfg.sv @@
// Layer configuration registers with saturation and output size computation.
// Depends on cle_pkg.
`timescale 1ns / 1ps

module cle_cfg import cle_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  we_i,
  input  logic [CFG_IDX_W-1:0]  index_i,
  input  logic [CFG_DATA_W-1:0] data_i,
  output cfg_t                  cfg_o
);

  logic [4:0] in_ch_q, out_ch_q;
  logic [3:0] ksize_q;
  logic [2:0] stride_q, pad_q;
  logic [6:0] width_q, height_q;

  logic [4:0] nic, noc;
  logic [3:0] k_eff;
  logic [2:0] s_eff, p_eff;
  logic [6:0] w_eff, h_eff;

  // (in + 2*pad - k) / stride + 1, or zero when the kernel does not fit
  function automatic logic [6:0] out_dim(input logic [6:0] in_d, input logic [3:0] k,
                                         input logic [2:0] s, input logic [2:0] p);
    logic signed [9:0] span;
    logic [6:0]        span_u;
    logic [14:0]       prod3;
    logic [6:0]        quo;
    span   = $signed(10'(in_d) + 10'({p, 1'b0}) - 10'(k));
    span_u = span[6:0];
    prod3  = 15'(span_u) * 15'(171);
    unique case (s)
      3'd1:    quo = span_u;
      3'd2:    quo = span_u >> 1;
      3'd3:    quo = prod3[15-1:9] & 7'h7f;
      3'd4:    quo = span_u >> 2;
      default: quo = span_u;
    endcase
    if (span[9]) begin
      return 7'd0;
    end
    return quo + 7'd1;
  endfunction

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch_q  <= 5'd1;
      out_ch_q <= 5'd1;
      ksize_q  <= 4'd3;
      stride_q <= 3'd1;
      pad_q    <= 3'd0;
      width_q  <= 7'd64;
      height_q <= 7'd64;
    end else if (we_i) begin
      unique case (index_i)
        REG_IN_CH:  in_ch_q  <= data_i[4:0];
        REG_OUT_CH: out_ch_q <= data_i[4:0];
        REG_KSIZE:  ksize_q  <= data_i[3:0];
        REG_STRIDE: stride_q <= data_i[2:0];
        REG_PAD:    pad_q    <= data_i[2:0];
        REG_WIDTH:  width_q  <= data_i[6:0];
        REG_HEIGHT: height_q <= data_i[6:0];
        default: ;
      endcase
    end
  end

  // Saturate into the legal ranges
  always_comb begin
    nic   = (in_ch_q == 5'd0) ? 5'd1 : ((in_ch_q > 5'(NIC_MAX)) ? 5'(NIC_MAX) : in_ch_q);
    noc   = (out_ch_q == 5'd0) ? 5'd1 : ((out_ch_q > 5'(NOC_MAX)) ? 5'(NOC_MAX) : out_ch_q);
    k_eff = (ksize_q == 4'd0) ? 4'd1 : ((ksize_q > 4'(K_MAX)) ? 4'(K_MAX) : ksize_q);
    s_eff = (stride_q == 3'd0) ? 3'd1 : ((stride_q > 3'd4) ? 3'd4 : stride_q);
    p_eff = (pad_q > 3'd4) ? 3'd4 : pad_q;
    w_eff = (width_q == 7'd0) ? 7'd1 : ((width_q > 7'(DIM_MAX)) ? 7'(DIM_MAX) : width_q);
    h_eff = (height_q == 7'd0) ? 7'd1 : ((height_q > 7'(DIM_MAX)) ? 7'(DIM_MAX) : height_q);
  end

  assign cfg_o = '{
    nic:    nic,
    noc:    noc,
    ksize:  k_eff,
    stride: s_eff,
    pad:    p_eff,
    width:  w_eff,
    height: h_eff,
    out_w:  out_dim(w_eff, k_eff, s_eff, p_eff),
    out_h:  out_dim(h_eff, k_eff, s_eff, p_eff)
  };

endmodule

@@ src/cle_stores.sv @@
// Weight and image memories (registered read) and the bias registers.
// Depends on cle_pkg.
`timescale 1ns / 1ps

module cle_stores import cle_pkg::*; (
  input  logic             clk_i,
  input  store_req_t       req_i,
  output logic [VAL_W-1:0] w_rdata_o,
  output logic [VAL_W-1:0] i_rdata_o,
  output logic [VAL_W-1:0] bias_o
);

  logic [VAL_W-1:0] wmem [W_DEPTH];
  logic [VAL_W-1:0] imem [I_DEPTH];
  logic [VAL_W-1:0] bias_q [MAX_OUT_CH];
  logic [VAL_W-1:0] w_rdata_q, i_rdata_q;

  // Weight memory: one port, write or read
  always_ff @(posedge clk_i) begin
    if (req_i.w_we) begin
      wmem[req_i.w_addr] <= req_i.wdata;
    end
    w_rdata_q <= wmem[req_i.w_addr];
  end

  // Image memory: one port, write or read
  always_ff @(posedge clk_i) begin
    if (req_i.i_we) begin
      imem[req_i.i_addr] <= req_i.wdata;
    end
    i_rdata_q <= imem[req_i.i_addr];
  end

  // One bias per output channel
  always_ff @(posedge clk_i) begin
    if (req_i.b_we) begin
      bias_q[req_i.b_addr] <= req_i.wdata;
    end
  end

  assign w_rdata_o = w_rdata_q;
  assign i_rdata_o = i_rdata_q;
  assign bias_o    = bias_q[req_i.b_addr];

endmodule

@@ src/cle_mac.sv @@
// Registered multiplier followed by the Q32.16 accumulator.
// Depends on cle_pkg.
`timescale 1ns / 1ps

module cle_mac import cle_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mac_ctl_t         ctl_i,
  input  logic [VAL_W-1:0] bias_i,
  input  logic [VAL_W-1:0] w_i,
  input  logic [VAL_W-1:0] p_i,
  output logic             busy_o,
  output logic [RES_W-1:0] acc_o
);

  logic signed [PROD_W-1:0] prod_q;
  logic                     prod_vld_q;
  logic [RES_W-1:0]         acc_q;

  // Product stage
  always_ff @(posedge clk_i) begin
    prod_q <= $signed(w_i) * $signed(p_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= ctl_i.tap_vld;
    end
  end

  // Accumulate; start from bias in Q32.16
  always_ff @(posedge clk_i) begin
    if (ctl_i.init) begin
      acc_q <= {{(RES_W-VAL_W-8){bias_i[VAL_W-1]}}, bias_i, 8'b0};
    end else if (prod_vld_q) begin
      acc_q <= acc_q + {{(RES_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
    end
  end

  assign busy_o = prod_vld_q;
  assign acc_o  = acc_q;

endmodule

@@ src/conv2d_layer_engine_core.sv @@
// Top level of the convolution layer engine: stream ports, item sequencer, tap walk.
// Depends on cle_pkg, cle_cfg, cle_stores and cle_mac.
`timescale 1ns / 1ps

// Multi-channel 2D convolution with stride and implicit zero padding, Q8.8 in and
// Q32.16 out. Load items (weight, bias, pixel) are taken while idle and give no beat.
// A compute item holds the input off until its result enters the output register;
// one weight/pixel pair is read from the weight and image memories per cycle and fed
// to a single shared multiply-accumulate, whose two pipeline stages then drain. A position
// outside the output returns status 1 and result 0 without walking any taps. Padding
// taps are walked but add nothing. A finished result waits in the output register while
// load items keep being accepted; the stores need no clearing after reset, but an entry
// must be written before a computation reads it.
module conv2d_layer_engine_core import cle_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Input items
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [39:0]           s_axis_tdata,  // out_ch[3:0] in_ch[7:4] row[13:8]
                                               // col[19:14] value[35:20], zero pad
  input  logic [1:0]            s_axis_tuser,  // func[1:0]
  // Result items
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [47:0]           m_axis_tdata,  // result[47:0]
  output logic [0:0]            m_axis_tuser,  // status[0]
  // Configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SETUP = 5'b00010,
    ST_RUN   = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  cfg_t       cfg;
  store_req_t req;
  mac_ctl_t   mac_ctl;

  logic [VAL_W-1:0] w_rdata, i_rdata, bias;
  logic [RES_W-1:0] acc;
  logic             mac_busy;

  // Input beat fields
  logic [FUNC_W-1:0] in_func;
  logic [CH_W-1:0]   in_oc, in_ic;
  logic [POS_W-1:0]  in_row, in_col;
  logic [VAL_W-1:0]  in_val;
  logic              in_acc;

  // Compute item context
  logic [CH_W-1:0]    oc_q;
  logic [POS_W-1:0]   row_q, col_q;
  logic signed [10:0] base_y_q, base_y_d, base_x_q, base_x_d;
  logic [IC_W-1:0]    c_q, c_d;
  logic [KER_W-1:0]   kr_q, kr_d, kc_q, kc_d;
  logic               err_q, err_d;
  logic               tap_vld_q;

  // Tap walk
  logic signed [10:0] iy, ix;
  logic               tap_ok, pos_err;
  logic [KER_W-1:0]   k_last;
  logic [IC_W-1:0]    c_last;

  // Output register
  logic             m_valid_q;
  logic [RES_W-1:0] m_data_q;
  logic             m_user_q;
  logic             out_load;

  assign in_func = s_axis_tuser;
  assign in_oc   = s_axis_tdata[3:0];
  assign in_ic   = s_axis_tdata[7:4];
  assign in_row  = s_axis_tdata[13:8];
  assign in_col  = s_axis_tdata[19:14];
  assign in_val  = s_axis_tdata[35:20];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  cle_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_valid_i),
    .index_i (cfg_index_i),
    .data_i  (cfg_data_i),
    .cfg_o   (cfg)
  );

  // Position check and window origin
  assign pos_err  = (5'(oc_q) >= cfg.noc) || (7'(row_q) >= cfg.out_h) ||
                    (7'(col_q) >= cfg.out_w);
  assign base_y_d = $signed(11'(row_q) * 11'(cfg.stride) - 11'(cfg.pad));
  assign base_x_d = $signed(11'(col_q) * 11'(cfg.stride) - 11'(cfg.pad));

  // Current tap and its bounds
  assign iy     = base_y_q + $signed(11'(kr_q));
  assign ix     = base_x_q + $signed(11'(kc_q));
  assign tap_ok = !iy[10] && !ix[10] && (iy[9:0] < 10'(cfg.height)) &&
                  (ix[9:0] < 10'(cfg.width));
  assign k_last = KER_W'(cfg.ksize - 4'd1);
  assign c_last = IC_W'(cfg.nic - 5'd1);

  // Store access: loads at the accepted beat, reads during the tap walk
  always_comb begin
    req.w_we   = 1'b0;
    req.i_we   = 1'b0;
    req.b_we   = 1'b0;
    req.w_addr = {oc_q, c_q, kr_q, kc_q};
    req.i_addr = {c_q, iy[DIM_W-1:0], ix[DIM_W-1:0]};
    req.b_addr = oc_q;
    req.wdata  = in_val;
    if (in_acc) begin
      unique case (in_func)
        FUNC_LOAD_W: begin
          req.w_addr = {in_oc, in_ic, in_row[KER_W-1:0], in_col[KER_W-1:0]};
          req.w_we   = (int'(in_oc) < MAX_OUT_CH) && (int'(in_ic) < MAX_IN_CH) &&
                       (int'(in_row) < MAX_KERNEL) && (int'(in_col) < MAX_KERNEL);
        end
        FUNC_LOAD_B: begin
          req.b_addr = in_oc;
          req.b_we   = (int'(in_oc) < MAX_OUT_CH);
        end
        FUNC_LOAD_P: begin
          req.i_addr = {in_ic, in_row[DIM_W-1:0], in_col[DIM_W-1:0]};
          req.i_we   = (int'(in_ic) < MAX_IN_CH) && (int'(in_row) < MAX_DIM) &&
                       (int'(in_col) < MAX_DIM);
        end
        default: ;
      endcase
    end
  end

  cle_stores u_stores (
    .clk_i     (clk_i),
    .req_i     (req),
    .w_rdata_o (w_rdata),
    .i_rdata_o (i_rdata),
    .bias_o    (bias)
  );

  assign mac_ctl.init    = (state_q == ST_SETUP) && !pos_err;
  assign mac_ctl.tap_vld = tap_vld_q;

  cle_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .bias_i (bias),
    .w_i    (w_rdata),
    .p_i    (i_rdata),
    .busy_o (mac_busy),
    .acc_o  (acc)
  );

  assign out_load = (state_q == ST_DONE) && (!m_valid_q || m_axis_tready);

  // Sequencer
  always_comb begin
    state_d = state_q;
    c_d     = c_q;
    kr_d    = kr_q;
    kc_d    = kc_q;
    err_d   = err_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (in_func == FUNC_COMPUTE)) begin
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        c_d   = '0;
        kr_d  = '0;
        kc_d  = '0;
        err_d = pos_err;
        state_d = pos_err ? ST_DONE : ST_RUN;
      end
      ST_RUN: begin
        if (kc_q == k_last) begin
          kc_d = '0;
          if (kr_q == k_last) begin
            kr_d = '0;
            if (c_q == c_last) begin
              state_d = ST_DRAIN;
            end else begin
              c_d = c_q + 1'b1;
            end
          end else begin
            kr_d = kr_q + 1'b1;
          end
        end else begin
          kc_d = kc_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!tap_vld_q && !mac_busy) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      tap_vld_q <= 1'b0;
      c_q       <= '0;
      kr_q      <= '0;
      kc_q      <= '0;
      err_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      tap_vld_q <= (state_q == ST_RUN) && tap_ok;
      c_q       <= c_d;
      kr_q      <= kr_d;
      kc_q      <= kc_d;
      err_q     <= err_d;
    end
  end

  // Item context, captured on the compute beat; window origin captured in setup
  always_ff @(posedge clk_i) begin
    if (in_acc && (in_func == FUNC_COMPUTE)) begin
      oc_q  <= in_oc;
      row_q <= in_row;
      col_q <= in_col;
    end
    if (state_q == ST_SETUP) begin
      base_y_q <= base_y_d;
      base_x_q <= base_x_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= err_q ? '0 : acc;
      m_user_q <= err_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

@@ verif/tb_conv2d_layer_engine_core.sv @@
// Self-checking testbench for conv2d_layer_engine_core: directed and random load/compute
// beats checked against an in-bench convolution predictor. Depends on cle_pkg and the RTL.
`timescale 1ns / 1ps

module tb_conv2d_layer_engine_core;
  import cle_pkg::*;

  localparam int SETTLE_CYCLES  = 32;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int PHASE_ITEMS    = 65;
  localparam int HOLD_OFF       = 1500;

  typedef struct packed {
    logic [RES_W-1:0] result;
    logic             status;
  } conv_result_t;

  typedef struct {
    int nic, noc, k, s, p, w, h, ow, oh;
  } layer_geom_t;

  // Predicts convolution sums from the accepted beats and checks returned results
  class conv_sum_checker;
    logic signed [VAL_W-1:0] weight_mem [W_DEPTH];
    logic signed [VAL_W-1:0] bias_mem   [MAX_OUT_CH];
    logic signed [VAL_W-1:0] pixel_mem  [I_DEPTH];
    logic [CFG_DATA_W-1:0]   regs [7];
    conv_result_t            pending_sums [$];
    int                      errors;

    function new();
      regs[REG_IN_CH]  = 7'd1;
      regs[REG_OUT_CH] = 7'd1;
      regs[REG_KSIZE]  = 7'd3;
      regs[REG_STRIDE] = 7'd1;
      regs[REG_PAD]    = 7'd0;
      regs[REG_WIDTH]  = 7'd64;
      regs[REG_HEIGHT] = 7'd64;
      errors = 0;
    endfunction

    function int sat(int v, int lo, int hi);
      return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] d);
      regs[idx] = d;
    endfunction

    // Effective layer shape: fields masked to register width, then saturated
    function layer_geom_t geom();
      layer_geom_t g;
      int span_w, span_h;
      g.nic = sat(int'(regs[REG_IN_CH] & 7'h1F), 1, NIC_MAX);
      g.noc = sat(int'(regs[REG_OUT_CH] & 7'h1F), 1, NOC_MAX);
      g.k   = sat(int'(regs[REG_KSIZE] & 7'h0F), 1, K_MAX);
      g.s   = sat(int'(regs[REG_STRIDE] & 7'h07), 1, 4);
      g.p   = sat(int'(regs[REG_PAD] & 7'h07), 0, 4);
      g.w   = sat(int'(regs[REG_WIDTH]), 1, DIM_MAX);
      g.h   = sat(int'(regs[REG_HEIGHT]), 1, DIM_MAX);
      span_w = g.w + 2 * g.p - g.k;
      span_h = g.h + 2 * g.p - g.k;
      g.ow = (span_w < 0) ? 0 : span_w / g.s + 1;
      g.oh = (span_h < 0) ? 0 : span_h / g.s + 1;
      return g;
    endfunction

    function int pending();
      return pending_sums.size();
    endfunction

    // Store update or expected sum for one accepted input beat
    function void note_item(func_e f, logic [3:0] oc, logic [3:0] ic, logic [5:0] r,
                            logic [5:0] c, logic [VAL_W-1:0] v);
      layer_geom_t  g;
      conv_result_t e;
      longint       acc;
      int           iy, ix;
      case (f)
        FUNC_LOAD_W: begin
          // rows and columns past the kernel store are dropped
          if (r < MAX_KERNEL && c < MAX_KERNEL) weight_mem[{oc, ic, r[2:0], c[2:0]}] = v;
        end
        FUNC_LOAD_B: bias_mem[oc] = v;
        FUNC_LOAD_P: pixel_mem[{ic, r, c}] = v;
        default: begin
          g = geom();
          if (oc >= g.noc || r >= g.oh || c >= g.ow) begin
            e.result = '0;
            e.status = 1'b1;
          end else begin
            acc = longint'(bias_mem[oc]) * 256;
            for (int ch = 0; ch < g.nic; ch++) begin
              for (int kr = 0; kr < g.k; kr++) begin
                iy = int'(r) * g.s + kr - g.p;
                if (iy < 0 || iy >= g.h) continue;
                for (int kc = 0; kc < g.k; kc++) begin
                  ix = int'(c) * g.s + kc - g.p;
                  if (ix < 0 || ix >= g.w) continue;
                  acc += longint'(weight_mem[{oc, 4'(ch), 3'(kr), 3'(kc)}]) *
                         longint'(pixel_mem[{4'(ch), 6'(iy), 6'(ix)}]);
                end
              end
            end
            e.result = acc[RES_W-1:0];
            e.status = 1'b0;
          end
          pending_sums.insert(pending_sums.size(), e);
        end
      endcase
    endfunction

    function void check_result(logic [RES_W-1:0] res, logic st);
      conv_result_t e;
      if (pending_sums.size() == 0) begin
        $display("%0t: unexpected result beat: actual %h status %b", $time, res, st);
        errors++;
        return;
      end
      e = pending_sums.pop_front();
      if (res !== e.result) begin
        $display("%0t: result mismatch: expected %h actual %h", $time, e.result, res);
        errors++;
      end
      if (st !== e.status) begin
        $display("%0t: status mismatch: expected %b actual %b", $time, e.status, st);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [39:0]           s_axis_tdata = '0;  // out_ch, in_ch, row, col, value, zero pad
  logic [1:0]            s_axis_tuser = '0;  // func
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [47:0]           m_axis_tdata;       // result
  logic [0:0]            m_axis_tuser;       // status
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  conv_sum_checker sb;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int sink_hold_cycles = 0;
  int items_sent = 0;

  // Entries already targeted by a load, so computes never read unwritten data
  bit w_written [W_DEPTH];
  bit b_written [MAX_OUT_CH];
  bit p_written [I_DEPTH];

  conv2d_layer_engine_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Beat monitors, sampled at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        sb.note_item(func_e'(s_axis_tuser), s_axis_tdata[3:0], s_axis_tdata[7:4],
                     s_axis_tdata[13:8], s_axis_tdata[19:14], s_axis_tdata[35:20]);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tdata, m_axis_tuser[0]);
      if (cfg_valid_i && cfg_ready_o)
        sb.write_reg(cfg_reg_e'(cfg_index_i), cfg_data_i);
    end
  end

  // Result side: random stalls, plus a long hold-off when requested
  initial begin
    forever begin
      @(negedge clk_i);
      if (sink_hold_cycles > 0) begin
        m_axis_tready = 1'b0;
        sink_hold_cycles--;
      end else begin
        m_axis_tready = ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // Ends the run when no beat moves on any channel for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("Verification failed");
    $finish;
  end

  function automatic logic [VAL_W-1:0] rand_value();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Drives one input beat; called and returns at a falling edge, tvalid left high
  task automatic issue_item(input func_e f, input logic [3:0] oc, input logic [3:0] ic,
                            input logic [5:0] r, input logic [5:0] c,
                            input logic [VAL_W-1:0] v);
    case (f)
      FUNC_LOAD_W: begin
        if (r < MAX_KERNEL && c < MAX_KERNEL) begin
          w_written[{oc, ic, r[2:0], c[2:0]}] = 1'b1;
          items_sent++;
        end
      end
      FUNC_LOAD_B: begin
        b_written[oc] = 1'b1;
        items_sent++;
      end
      FUNC_LOAD_P: begin
        p_written[{ic, r, c}] = 1'b1;
        items_sent++;
      end
      default: items_sent++;
    endcase
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tuser  = f;
    s_axis_tdata  = {4'b0, v, c, r, ic, oc};
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // Loads every entry a valid compute would read that has not been written yet
  task automatic prep_compute(input logic [3:0] oc, input logic [5:0] r, input logic [5:0] c);
    layer_geom_t g;
    int iy, ix;
    g = sb.geom();
    if (oc >= g.noc || r >= g.oh || c >= g.ow) return;
    if (!b_written[oc])
      issue_item(FUNC_LOAD_B, oc, 4'($urandom), 6'($urandom), 6'($urandom), rand_value());
    for (int ch = 0; ch < g.nic; ch++) begin
      for (int kr = 0; kr < g.k; kr++) begin
        iy = int'(r) * g.s + kr - g.p;
        if (iy < 0 || iy >= g.h) continue;
        for (int kc = 0; kc < g.k; kc++) begin
          ix = int'(c) * g.s + kc - g.p;
          if (ix < 0 || ix >= g.w) continue;
          if (!w_written[{oc, 4'(ch), 3'(kr), 3'(kc)}])
            issue_item(FUNC_LOAD_W, oc, 4'(ch), 6'(kr), 6'(kc), rand_value());
          if (!p_written[{4'(ch), 6'(iy), 6'(ix)}])
            issue_item(FUNC_LOAD_P, 4'($urandom), 4'(ch), 6'(iy), 6'(ix), rand_value());
        end
      end
    end
  endtask

  task automatic issue_compute(input logic [3:0] oc, input logic [5:0] r, input logic [5:0] c);
    prep_compute(oc, r, c);
    issue_item(FUNC_COMPUTE, oc, 4'($urandom), r, c, 16'($urandom));
  endtask

  task automatic write_cfg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] d);
    cfg_index_i = idx;
    cfg_data_i  = d;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic write_layer(input logic [6:0] nic, input logic [6:0] noc, input logic [6:0] k,
                             input logic [6:0] s, input logic [6:0] p, input logic [6:0] w,
                             input logic [6:0] h);
    write_cfg(REG_IN_CH, nic);
    write_cfg(REG_OUT_CH, noc);
    write_cfg(REG_KSIZE, k);
    write_cfg(REG_STRIDE, s);
    write_cfg(REG_PAD, p);
    write_cfg(REG_WIDTH, w);
    write_cfg(REG_HEIGHT, h);
  endtask

  // Drains all expected results, then lets trailing loads finish
  task automatic settle();
    s_axis_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Random mix of loads and computes, weighted toward the configured layer
  task automatic run_random(input int quota, input bit hold_sink);
    layer_geom_t g;
    int          start, pick, sel;
    logic [5:0]  r, c;
    g = sb.geom();
    start = items_sent;
    if (hold_sink) sink_hold_cycles = HOLD_OFF;
    while (items_sent - start < quota) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        if (g.ow > 0 && g.oh > 0 && $urandom_range(4) != 0)
          issue_compute(4'($urandom_range(g.noc - 1)), 6'($urandom_range(g.oh - 1)),
                        6'($urandom_range(g.ow - 1)));
        else
          issue_compute(4'($urandom), 6'($urandom), 6'($urandom));
      end else if (pick < 70) begin
        sel = $urandom_range(9);
        if (sel < 7) begin
          issue_item(FUNC_LOAD_W, 4'($urandom_range(g.noc - 1)), 4'($urandom_range(g.nic - 1)),
                     6'($urandom_range(g.k - 1)), 6'($urandom_range(g.k - 1)), rand_value());
        end else if (sel < 9) begin
          issue_item(FUNC_LOAD_W, 4'($urandom), 4'($urandom), 6'($urandom_range(7)),
                     6'($urandom_range(7)), rand_value());
        end else begin
          // outside the kernel store: dropped by the block
          r = 6'($urandom_range(8, 63));
          c = 6'($urandom);
          if ($urandom_range(1)) issue_item(FUNC_LOAD_W, 4'($urandom), 4'($urandom), r, c,
                                            rand_value());
          else issue_item(FUNC_LOAD_W, 4'($urandom), 4'($urandom), c, r, rand_value());
        end
      end else if (pick < 78) begin
        issue_item(FUNC_LOAD_B, 4'($urandom), 4'($urandom), 6'($urandom), 6'($urandom),
                   rand_value());
      end else if ($urandom_range(9) < 7) begin
        issue_item(FUNC_LOAD_P, 4'($urandom), 4'($urandom_range(g.nic - 1)),
                   6'($urandom_range(g.h - 1)), 6'($urandom_range(g.w - 1)), rand_value());
      end else begin
        issue_item(FUNC_LOAD_P, 4'($urandom), 4'($urandom), 6'($urandom), 6'($urandom),
                   rand_value());
      end
    end
  endtask

  initial begin : stimulus
    sb = new();
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed beats under the reset layer: 1 channel, 3x3 kernel, 64x64 image
    issue_item(FUNC_LOAD_W, 4'd0, 4'd0, 6'd2, 6'd2, 16'h8000);
    issue_item(FUNC_LOAD_P, 4'd0, 4'd0, 6'd63, 6'd63, 16'h8000);
    issue_item(FUNC_LOAD_W, 4'd0, 4'd0, 6'd0, 6'd0, 16'h7FFF);
    issue_item(FUNC_LOAD_P, 4'd15, 4'd0, 6'd61, 6'd61, 16'h7FFF);
    issue_item(FUNC_LOAD_B, 4'd0, 4'd15, 6'd63, 6'd63, 16'h7FFF);
    issue_item(FUNC_LOAD_W, 4'd15, 4'd15, 6'd7, 6'd7, 16'h8000);
    issue_item(FUNC_LOAD_B, 4'd15, 4'd0, 6'd0, 6'd0, 16'h8000);
    // weight rows or columns beyond the kernel store are ignored
    issue_item(FUNC_LOAD_W, 4'd0, 4'd0, 6'd8, 6'd0, 16'h1234);
    issue_item(FUNC_LOAD_W, 4'd0, 4'd0, 6'd1, 6'd63, 16'hFFFF);
    // last valid output position, then positions past the output and a channel out of use
    issue_compute(4'd0, 6'd61, 6'd61);
    issue_compute(4'd0, 6'd62, 6'd0);
    issue_compute(4'd0, 6'd0, 6'd62);
    issue_compute(4'd15, 6'd63, 6'd63);
    issue_compute(4'd1, 6'd5, 6'd5);

    for (int ph = 1; ph <= 8; ph++) begin
      settle();
      case (ph)
        1: write_layer(7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0);
        2: write_layer(7'd31, 7'd31, 7'd15, 7'd7, 7'd7, 7'd1, 7'd1);
        3: write_layer(7'd1, 7'd1, 7'd8, 7'd1, 7'd0, 7'd5, 7'd5);  // kernel wider than image
        4: write_layer(7'd3, 7'd4, 7'd2, 7'd2, 7'd1, 7'd127, 7'd100);
        5: write_layer(7'd2, 7'd16, 7'd1, 7'd1, 7'd0, 7'd17, 7'd9);
        6: write_layer(7'd4, 7'd3, 7'd3, 7'd3, 7'd2, 7'd12, 7'd20);
        default: write_layer(7'($urandom_range(1, 4)), 7'($urandom_range(20)),
                             7'($urandom_range(4)), 7'($urandom_range(7)),
                             7'($urandom_range(7)), 7'($urandom_range(127)),
                             7'($urandom_range(127)));
      endcase
      case (ph % 4)
        1: begin
          src_idle_pct   = 54;
          sink_stall_pct = 0;
        end
        2: begin
          src_idle_pct   = 0;
          sink_stall_pct = 54;
        end
        3: begin
          src_idle_pct   = 10;
          sink_stall_pct = 10;
        end
        default: begin
          src_idle_pct   = 0;
          sink_stall_pct = 0;
        end
      endcase
      run_random(PHASE_ITEMS, ph == 5);
    end

    settle();
    if (sb.errors == 0 && sb.pending() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
